/* rtl/divenum_pkg.sv */
// Shared constants, types and state encodings for the divisor enumerator.
`timescale 1ns / 1ps
`default_nettype none

package divenum_pkg;

  localparam int unsigned VALUE_WIDTH_DEF  = 12;
  localparam int unsigned STACK_DEPTH_DEF  = 24;
  localparam int unsigned MAX_DIVISORS_DEF = 48;

  localparam int unsigned IN_WIDTH    = 13;
  localparam int unsigned OUT_WIDTH   = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                 empty;
    logic [OUT_WIDTH-1:0] value;
  } task_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_POP_RD,
    BK_POP_EMIT,
    BK_FINISH
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/divenum_front.sv */
// Front end: takes items, classifies and saturates them, and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module divenum_front import divenum_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [IN_WIDTH-1:0] value_i,
  output logic                            busy_o,
  output logic                            head_valid_o,
  output task_t                           head_o,
  input  wire logic                       pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IN_WIDTH-2:0] MaxVal = (IN_WIDTH-1)'((1 << VALUE_WIDTH) - 1);

  task_t            entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IN_WIDTH-2:0] mag;
  task_t            incoming;
  logic             push;

  assign mag = value_i[IN_WIDTH-2:0];

  always_comb begin
    incoming.empty = value_i[IN_WIDTH-1] | (value_i == '0);
    if (incoming.empty) begin
      incoming.value = '0;
    end else if (mag > MaxVal) begin
      incoming.value = OUT_WIDTH'(MaxVal);
    end else begin
      incoming.value = OUT_WIDTH'(mag);
    end
  end

  assign busy_o       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign push         = start_i & ~busy_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i && head_valid_o) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !(pop_i && head_valid_o)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i && head_valid_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

`default_nettype wire

/* rtl/divenum_div.sv */
// Bit-serial restoring divider that yields the quotient and a zero-remainder flag.
`timescale 1ns / 1ps
`default_nettype none

module divenum_div import divenum_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned TRIAL_WIDTH = (VALUE_WIDTH + 1) / 2 + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [TRIAL_WIDTH-1:0] divisor_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      quot_o,
  output logic                        rem_zero_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [TRIAL_WIDTH-1:0] rem_q, rem_d;
  logic [TRIAL_WIDTH-1:0] dsr_q, dsr_d;
  logic [TRIAL_WIDTH:0]   rem_sh;
  logic [TRIAL_WIDTH:0]   diff;
  logic                   fits;

  assign rem_sh = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[TRIAL_WIDTH-1:0] : rem_sh[TRIAL_WIDTH-1:0];
      quot_d = {quot_q[VALUE_WIDTH-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o     = done_q;
  assign quot_o     = quot_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

`default_nettype wire

/* rtl/divenum_back.sv */
// Back end: trial-division sequencer, cofactor stack and result emission.
`timescale 1ns / 1ps
`default_nettype none

module divenum_back import divenum_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int unsigned MAX_DIVISORS = MAX_DIVISORS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire task_t         head_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [OUT_WIDTH-1:0] divisor_o,
  output logic               last_o,
  output logic               empty_res_o
);

  localparam int unsigned TW  = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW  = $clog2(MAX_DIVISORS + 1);

  back_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [TW-1:0]          t_q, t_d;
  logic [SPW-1:0]         sp_q, sp_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] pend_q, pend_d;
  logic                   pend_valid_q, pend_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_WIDTH-1:0]   out_div_q, out_div_d;
  logic                   out_last_q, out_last_d;
  logic                   out_empty_q, out_empty_d;

  logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q;
  logic [SPW-1:0]         sp_dec;
  logic                   push_en;
  logic                   rd_en;

  logic [2*TW-1:0]        tsq;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic                   div_rem_zero;
  logic                   prod_en;
  logic [VALUE_WIDTH-1:0] prod_val;

  divenum_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TRIAL_WIDTH (TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (t_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_zero_o (div_rem_zero)
  );

  assign tsq    = t_q * t_q;
  assign sp_dec = sp_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    t_d          = t_q;
    sp_d         = sp_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = 1'b0;
    out_div_d    = out_div_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    push_en      = 1'b0;
    rd_en        = 1'b0;
    prod_en      = 1'b0;
    prod_val     = rd_data_q;
    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          if (head_i.empty) begin
            out_valid_d = 1'b1;
            out_div_d   = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
          end else begin
            n_d          = head_i.value[VALUE_WIDTH-1:0];
            t_d          = TW'(1);
            sp_d         = '0;
            cnt_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = BK_CHECK;
          end
        end
      end
      BK_CHECK: begin
        if (tsq <= (2*TW)'(n_q)) begin
          div_start = 1'b1;
          state_d   = BK_DIV;
        end else begin
          state_d = BK_POP_RD;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          if (div_rem_zero) begin
            prod_en  = 1'b1;
            prod_val = VALUE_WIDTH'(t_q);
            if ((div_quot != VALUE_WIDTH'(t_q)) && (sp_q < SPW'(STACK_DEPTH))) begin
              push_en = 1'b1;
              sp_d    = sp_q + 1'b1;
            end
          end
          t_d     = t_q + 1'b1;
          state_d = BK_CHECK;
        end
      end
      BK_POP_RD: begin
        if (sp_q == '0) begin
          state_d = BK_FINISH;
        end else begin
          rd_en   = 1'b1;
          sp_d    = sp_dec;
          state_d = BK_POP_EMIT;
        end
      end
      BK_POP_EMIT: begin
        prod_en = 1'b1;
        state_d = BK_POP_RD;
      end
      BK_FINISH: begin
        out_valid_d  = pend_valid_q;
        out_div_d    = OUT_WIDTH'(pend_q);
        out_last_d   = 1'b1;
        out_empty_d  = 1'b0;
        pend_valid_d = 1'b0;
        state_d      = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // A divisor is held back one step so that the final one can carry the last flag.
    if (prod_en && (cnt_q < CW'(MAX_DIVISORS))) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_div_d   = OUT_WIDTH'(pend_q);
        out_last_d  = 1'b0;
        out_empty_d = 1'b0;
      end
      pend_d       = prod_val;
      pend_valid_d = 1'b1;
      cnt_d        = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      n_q          <= '0;
      t_q          <= '0;
      sp_q         <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      t_q          <= t_d;
      sp_q         <= sp_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    out_div_q   <= out_div_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[sp_q[SAW-1:0]] <= div_quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= stack_mem[sp_dec[SAW-1:0]];
    end
  end

  assign valid_o     = out_valid_q;
  assign divisor_o   = out_div_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("Cofactor stack pointer exceeds the stack depth.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_DIVISORS))
    else $error("Result count exceeds the divisor limit.");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_last_q && (out_div_q == '0)))
    else $error("An empty result must be last and carry a zero divisor.");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> pend_valid_q)
    else $error("A result that is not last must leave a divisor pending.");

  a_finish_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FINISH) |-> pend_valid_q)
    else $error("A run finished without a pending divisor.");
`endif

endmodule

`default_nettype wire

/* rtl/divisor_enumerator.sv */
// Top level of the divisor enumerator: front-end queue feeding the trial-division back end.
`timescale 1ns / 1ps
`default_nettype none

// Each item is a signed value; the block returns its positive divisors in ascending order,
// one per result, with the final result of the run marked by last_o. A value of zero or
// below returns a single result with empty_res_o set. An item is taken when start_i is high
// and busy_o is low; a two-entry queue holds items while an earlier one is being worked on,
// and busy_o rises only when that queue is full. Results appear for exactly one cycle with
// valid_o high and cannot be held off. For a positive value n, the run tests each trial
// divisor from 1 up to floor(sqrt(n)) in turn on the bit-serial divider, one trial divisor
// at a time, and then takes each large divisor back off the cofactor stack.

module divisor_enumerator import divenum_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int unsigned MAX_DIVISORS = MAX_DIVISORS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic signed [IN_WIDTH-1:0] value_i,
  output logic                            valid_o,
  output logic [OUT_WIDTH-1:0]            divisor_o,
  output logic                            last_o,
  output logic                            empty_res_o
);

  logic  head_valid;
  task_t head;
  logic  head_pop;

  divenum_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (head_pop)
  );

  divenum_back #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .STACK_DEPTH  (STACK_DEPTH),
    .MAX_DIVISORS (MAX_DIVISORS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (head_pop),
    .valid_o      (valid_o),
    .divisor_o    (divisor_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o)
  );

endmodule

`default_nettype wire
